@@ sv/cplb_pkg.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// cplb_pkg
// Shared constants, input kind codes, register indexes and the command and
// status groups that join the pair list controller and datapath.
// ----------------------------------------------------------------------------
package cplb_pkg;

	// Default sizes of the receptor store and the coordinate precision.
	localparam int RECEPTOR_ATOMS_DEF = 64;
	localparam int COORD_BITS_DEF     = 16;

	// Fixed field widths of the ports.
	localparam int KIND_W      = 2;
	localparam int FIELD_W     = 16;
	localparam int LIG_W       = 16;
	localparam int RIDX_W      = 6;
	localparam int CUTOFF_W    = 36;
	localparam int CFG_DATA_W  = 36;
	localparam int CFG_INDEX_W = 1;

	// Input transaction kinds.
	localparam logic [KIND_W-1:0] KIND_CLEAR  = 2'd0;
	localparam logic [KIND_W-1:0] KIND_APPEND = 2'd1;
	localparam logic [KIND_W-1:0] KIND_QUERY  = 2'd2;

	// Configuration register indexes.
	localparam logic [CFG_INDEX_W-1:0] REG_SQUARED_CUTOFF = 1'd0;
	localparam logic [CFG_INDEX_W-1:0] REG_ALL_PAIRS_MODE = 1'd1;

	// Commands from the controller to the datapath.
	typedef struct packed {
		logic clear;
		logic append;
		logic load_query;
		logic issue;
		logic flush;
	} cplb_cmd_t;

	// Status from the datapath to the controller.
	typedef struct packed {
		logic adv;
		logic count_zero;
		logic scan_last;
		logic pipe_empty;
		logic pend_valid;
	} cplb_status_t;

endpackage

@@ sv/cplb_ram.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// cplb_ram
// Generic single write port, single read port RAM with a registered read.
// ----------------------------------------------------------------------------
module cplb_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 64
) (
	input  logic                                        clk,
	input  logic                                        we,
	input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] waddr,
	input  logic [WIDTH-1:0]                            wdata,
	input  logic                                        re,
	input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] raddr,
	output logic [WIDTH-1:0]                            rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];

	// Write port.
	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
	end

	// Registered read port; the data holds while re is low.
	always_ff @(posedge clk) begin
		if (re) begin
			rdata <= mem_q[raddr];
		end
	end

endmodule

@@ sv/cplb_ctrl.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// cplb_ctrl
// Controller for the pair list builder: takes input transactions, starts the
// walk over the receptor store and flushes the final pair of each query.
// ----------------------------------------------------------------------------
module cplb_ctrl (
	input  logic                         clk,
	input  logic                         arst_n,
	input  logic                         in_valid,
	output logic                         in_stall,
	input  logic [cplb_pkg::KIND_W-1:0]  kind,
	input  cplb_pkg::cplb_status_t       status,
	output cplb_pkg::cplb_cmd_t          cmd
);

	localparam logic [1:0] ST_IDLE  = 2'd0;
	localparam logic [1:0] ST_SCAN  = 2'd1;
	localparam logic [1:0] ST_DRAIN = 2'd2;

	logic [1:0] state_q;
	logic [1:0] state_d;
	logic       accept;

	// Input transactions are taken only while no query is in flight.
	assign in_stall = (state_q != ST_IDLE);
	assign accept   = in_valid && !in_stall;

	// Command decode.
	always_comb begin
		cmd            = '0;
		cmd.clear      = accept && (kind == cplb_pkg::KIND_CLEAR);
		cmd.append     = accept && (kind == cplb_pkg::KIND_APPEND);
		cmd.load_query = accept && (kind == cplb_pkg::KIND_QUERY);
		cmd.issue      = (state_q == ST_SCAN);
		cmd.flush      = (state_q == ST_DRAIN) && status.adv && status.pipe_empty;
	end

	// Next state.
	always_comb begin
		state_d = state_q;
		unique case (state_q)
			ST_IDLE: begin
				if (cmd.load_query && !status.count_zero) begin
					state_d = ST_SCAN;
				end
			end
			ST_SCAN: begin
				if (status.adv && status.scan_last) begin
					state_d = ST_DRAIN;
				end
			end
			ST_DRAIN: begin
				if (cmd.flush) begin
					state_d = ST_IDLE;
				end
			end
			default: begin
				state_d = ST_IDLE;
			end
		endcase
	end

	// State register.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

endmodule

@@ sv/cplb_datapath.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// cplb_datapath
// Receptor store, query registers, distance pipeline, pending pair register
// and output register of the pair list builder.
// ----------------------------------------------------------------------------
module cplb_datapath #(
	parameter int RECEPTOR_ATOMS = cplb_pkg::RECEPTOR_ATOMS_DEF,
	parameter int COORD_BITS     = cplb_pkg::COORD_BITS_DEF
) (
	input  logic                               clk,
	input  logic                               arst_n,
	input  cplb_pkg::cplb_cmd_t                cmd,
	output cplb_pkg::cplb_status_t             status,
	input  logic signed [cplb_pkg::FIELD_W-1:0] atom_x,
	input  logic signed [cplb_pkg::FIELD_W-1:0] atom_y,
	input  logic signed [cplb_pkg::FIELD_W-1:0] atom_z,
	input  logic                               atom_active,
	input  logic [cplb_pkg::LIG_W-1:0]         ligand_number,
	input  logic [cplb_pkg::CUTOFF_W-1:0]      squared_cutoff,
	input  logic                               all_pairs_mode,
	output logic                               out_valid,
	input  logic                               out_stall,
	output logic [cplb_pkg::LIG_W-1:0]         ligand_index,
	output logic [cplb_pkg::RIDX_W-1:0]        receptor_index,
	output logic                               last_pair
);

	localparam int CW    = (COORD_BITS < cplb_pkg::FIELD_W) ? COORD_BITS : cplb_pkg::FIELD_W;
	localparam int AW    = (RECEPTOR_ATOMS > 1) ? $clog2(RECEPTOR_ATOMS) : 1;
	localparam int CNT_W = $clog2(RECEPTOR_ATOMS + 1);
	localparam int RAM_W = 3 * CW + 1;
	localparam int SQ_W  = 2 * CW + 2;
	localparam int SUM_W = SQ_W + 2;

	// Store fill count and write port.
	logic [CNT_W-1:0] count_q;
	logic             full;
	logic             ram_we;
	logic [RAM_W-1:0] ram_wdata;
	logic [RAM_W-1:0] ram_rdata;
	logic             ram_re;

	// Query registers.
	logic [CW-1:0]                qx_q, qy_q, qz_q;
	logic                         qact_q;
	logic [cplb_pkg::LIG_W-1:0]   lig_q;

	// Scan address and pipeline.
	logic [AW-1:0]     j_q;
	logic              adv;
	logic              valid_s1;
	logic [AW-1:0]     idx_s1;
	logic [CW-1:0]     sx, sy, sz;
	logic              sact;
	logic signed [CW:0]      dx, dy, dz;
	logic signed [SQ_W-1:0]  px, py, pz;
	logic              valid_s2;
	logic [AW-1:0]     idx_s2;
	logic              act_s2;
	logic [SQ_W-1:0]   sqx_s2, sqy_s2, sqz_s2;
	logic [SUM_W-1:0]  sum;
	logic              in_range;
	logic              take;

	// Pending pair and output register.
	logic              pend_valid_q;
	logic [AW-1:0]     pend_idx_q;
	logic              load_out;

	// The whole walk moves only when the output register can take a pair.
	assign adv = !out_valid || !out_stall;

	// Store fill count.
	assign full = (count_q == CNT_W'(RECEPTOR_ATOMS));

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			count_q <= '0;
		end else if (cmd.clear) begin
			count_q <= '0;
		end else if (ram_we) begin
			count_q <= count_q + CNT_W'(1);
		end
	end

	// Store write: appends beyond capacity are dropped.
	assign ram_we    = cmd.append && !full;
	assign ram_wdata = {atom_x[CW-1:0], atom_y[CW-1:0], atom_z[CW-1:0], atom_active};
	assign ram_re    = cmd.issue && adv;

	cplb_ram #(
		.WIDTH(RAM_W),
		.DEPTH(RECEPTOR_ATOMS)
	) u_store (
		.clk  (clk),
		.we   (ram_we),
		.waddr(count_q[AW-1:0]),
		.wdata(ram_wdata),
		.re   (ram_re),
		.raddr(j_q),
		.rdata(ram_rdata)
	);

	// Query capture.
	always_ff @(posedge clk) begin
		if (cmd.load_query) begin
			qx_q   <= atom_x[CW-1:0];
			qy_q   <= atom_y[CW-1:0];
			qz_q   <= atom_z[CW-1:0];
			qact_q <= atom_active;
			lig_q  <= ligand_number;
		end
	end

	// Scan address counter.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			j_q <= '0;
		end else if (cmd.load_query) begin
			j_q <= '0;
		end else if (ram_re) begin
			j_q <= j_q + AW'(1);
		end
	end

	// Stage 1: the store read is in flight.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (adv) begin
			valid_s1 <= cmd.issue;
		end
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			idx_s1 <= j_q;
		end
	end

	// Coordinate differences and squares from the store entry.
	assign {sx, sy, sz, sact} = ram_rdata;
	assign dx = {qx_q[CW-1], qx_q} - {sx[CW-1], sx};
	assign dy = {qy_q[CW-1], qy_q} - {sy[CW-1], sy};
	assign dz = {qz_q[CW-1], qz_q} - {sz[CW-1], sz};
	assign px = dx * dx;
	assign py = dy * dy;
	assign pz = dz * dz;

	// Stage 2: registered squares.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s2 <= 1'b0;
		end else if (adv) begin
			valid_s2 <= valid_s1;
		end
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			idx_s2 <= idx_s1;
			act_s2 <= sact;
			sqx_s2 <= $unsigned(px);
			sqy_s2 <= $unsigned(py);
			sqz_s2 <= $unsigned(pz);
		end
	end

	// Distance sum and filter decision.
	assign sum      = SUM_W'(sqx_s2) + SUM_W'(sqy_s2) + SUM_W'(sqz_s2);
	assign in_range = (cplb_pkg::CUTOFF_W'(sum) <= squared_cutoff);
	assign take     = valid_s2 && (all_pairs_mode || (qact_q && act_s2 && in_range));

	// A pair waits in the pending register until the next one or the end of
	// the walk shows whether it is the last of its query.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pend_valid_q <= 1'b0;
		end else if (adv && take) begin
			pend_valid_q <= 1'b1;
		end else if (cmd.flush) begin
			pend_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (adv && take) begin
			pend_idx_q <= idx_s2;
		end
	end

	// Output register.
	assign load_out = adv && pend_valid_q && (take || cmd.flush);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid <= 1'b0;
		end else if (load_out) begin
			out_valid <= 1'b1;
		end else if (!out_stall) begin
			out_valid <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (load_out) begin
			ligand_index   <= lig_q;
			receptor_index <= cplb_pkg::RIDX_W'(pend_idx_q);
			last_pair      <= cmd.flush;
		end
	end

	// Status to the controller.
	always_comb begin
		status            = '0;
		status.adv        = adv;
		status.count_zero = (count_q == '0);
		status.scan_last  = ((CNT_W'(j_q) + CNT_W'(1)) == count_q);
		status.pipe_empty = !valid_s1 && !valid_s2;
		status.pend_valid = pend_valid_q;
	end

endmodule

@@ sv/cutoff_pair_list_builder.sv @@
`timescale 1ns / 1ps
// A pair reaches the output after its query transaction; it is held in the pending
// register until the next pair or the end of the walk shows whether it is last.
// Clear, append and an empty-store query need no walk; other queries walk the store
// one receptor atom per cycle while the output does not stall.
// Reset: asynchronous; clears the control state, the config and valid registers
// and the store count. Store contents stay undefined and need no clearing pass.
// ----------------------------------------------------------------------------
// cutoff_pair_list_builder
// Brute force cutoff neighbor pair list: receptor atoms fill a store, and each
// ligand query walks the store and gives every pair within the cutoff.
// ----------------------------------------------------------------------------
module cutoff_pair_list_builder #(
	parameter int RECEPTOR_ATOMS = cplb_pkg::RECEPTOR_ATOMS_DEF,
	parameter int COORD_BITS     = cplb_pkg::COORD_BITS_DEF
) (
	input  logic                                  clk,
	input  logic                                  arst_n,
	input  logic                                  cfg_write_en,
	input  logic [cplb_pkg::CFG_INDEX_W-1:0]      cfg_index,
	input  logic [cplb_pkg::CFG_DATA_W-1:0]       cfg_data,
	input  logic                                  in_valid,
	output logic                                  in_stall,
	input  logic [cplb_pkg::KIND_W-1:0]           kind,
	input  logic signed [cplb_pkg::FIELD_W-1:0]   atom_x,
	input  logic signed [cplb_pkg::FIELD_W-1:0]   atom_y,
	input  logic signed [cplb_pkg::FIELD_W-1:0]   atom_z,
	input  logic                                  atom_active,
	input  logic [cplb_pkg::LIG_W-1:0]            ligand_number,
	output logic                                  out_valid,
	input  logic                                  out_stall,
	output logic [cplb_pkg::LIG_W-1:0]            ligand_index,
	output logic [cplb_pkg::RIDX_W-1:0]           receptor_index,
	output logic                                  last_pair
);

	logic [cplb_pkg::CUTOFF_W-1:0] squared_cutoff_q;
	logic                          all_pairs_mode_q;
	cplb_pkg::cplb_cmd_t           cmd;
	cplb_pkg::cplb_status_t        status;

	// Configuration registers.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			squared_cutoff_q <= '0;
			all_pairs_mode_q <= 1'b0;
		end else if (cfg_write_en) begin
			unique case (cfg_index)
				cplb_pkg::REG_SQUARED_CUTOFF: begin
					squared_cutoff_q <= cfg_data[cplb_pkg::CUTOFF_W-1:0];
				end
				cplb_pkg::REG_ALL_PAIRS_MODE: begin
					all_pairs_mode_q <= cfg_data[0];
				end
				default: begin
				end
			endcase
		end
	end

	// Controller.
	cplb_ctrl u_ctrl (
		.clk     (clk),
		.arst_n  (arst_n),
		.in_valid(in_valid),
		.in_stall(in_stall),
		.kind    (kind),
		.status  (status),
		.cmd     (cmd)
	);

	// Datapath.
	cplb_datapath #(
		.RECEPTOR_ATOMS(RECEPTOR_ATOMS),
		.COORD_BITS    (COORD_BITS)
	) u_datapath (
		.clk           (clk),
		.arst_n        (arst_n),
		.cmd           (cmd),
		.status        (status),
		.atom_x        (atom_x),
		.atom_y        (atom_y),
		.atom_z        (atom_z),
		.atom_active   (atom_active),
		.ligand_number (ligand_number),
		.squared_cutoff(squared_cutoff_q),
		.all_pairs_mode(all_pairs_mode_q),
		.out_valid     (out_valid),
		.out_stall     (out_stall),
		.ligand_index  (ligand_index),
		.receptor_index(receptor_index),
		.last_pair     (last_pair)
	);

	// A held pair means a query is still in flight, so no new input is taken.
	assert property (@(posedge clk) disable iff (!arst_n)
		status.pend_valid |-> in_stall)
		else $error("pending pair while input is open");

	// The final flush of a query returns the controller to idle.
	assert property (@(posedge clk) disable iff (!arst_n)
		cmd.flush |=> !in_stall)
		else $error("controller did not return to idle after flush");

	// Once the last pair of a query is taken, nothing of it remains pending.
	assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid && !out_stall && last_pair) |=> !status.pend_valid)
		else $error("pair left pending after the last pair");

	// A pending pair only exists for a non-empty store.
	assert property (@(posedge clk) disable iff (!arst_n)
		status.pend_valid |-> !status.count_zero)
		else $error("pending pair with an empty store");

endmodule

@@ verif/tb.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb
// Self-checking bench for the cutoff pair list builder. A directed part covers
// the coordinate extremes, the cutoff boundary, inactive atoms, all-pairs mode,
// an empty store and the unused kind. Random phases then load receptor clusters,
// the first one past the full store, and query them under changing register
// settings. A local model of the store predicts every pair, and the output
// monitor compares each pair with the oldest prediction.
// ----------------------------------------------------------------------------
module tb;

	localparam int STORE_DEPTH = cplb_pkg::RECEPTOR_ATOMS_DEF;
	localparam int RANDOM_ITEMS = 290;
	localparam int DRAIN_CYCLES = STORE_DEPTH + 16;
	localparam int CYCLE_LIMIT = 3000000;
	localparam logic [cplb_pkg::KIND_W-1:0] KIND_UNUSED = 2'd3;
	localparam logic [cplb_pkg::CUTOFF_W-1:0] CUTOFF_MAX = {cplb_pkg::CUTOFF_W{1'b1}};

	typedef struct {
		logic [cplb_pkg::KIND_W-1:0] kind;
		logic signed [cplb_pkg::FIELD_W-1:0] x;
		logic signed [cplb_pkg::FIELD_W-1:0] y;
		logic signed [cplb_pkg::FIELD_W-1:0] z;
		logic active;
		logic [cplb_pkg::LIG_W-1:0] lig;
	} atom_item_t;

	typedef struct {
		logic [cplb_pkg::LIG_W-1:0] lig;
		logic [cplb_pkg::RIDX_W-1:0] ridx;
		logic last;
	} pair_t;

	logic clk = 1'b0;
	logic arst_n = 1'b0;
	logic cfg_write_en = 1'b0;
	logic [cplb_pkg::CFG_INDEX_W-1:0] cfg_index = '0;
	logic [cplb_pkg::CFG_DATA_W-1:0] cfg_data = '0;
	logic in_valid = 1'b0;
	logic in_stall;
	logic [cplb_pkg::KIND_W-1:0] kind = '0;
	logic signed [cplb_pkg::FIELD_W-1:0] atom_x = '0;
	logic signed [cplb_pkg::FIELD_W-1:0] atom_y = '0;
	logic signed [cplb_pkg::FIELD_W-1:0] atom_z = '0;
	logic atom_active = 1'b0;
	logic [cplb_pkg::LIG_W-1:0] ligand_number = '0;
	logic out_valid;
	logic out_stall = 1'b0;
	logic [cplb_pkg::LIG_W-1:0] ligand_index;
	logic [cplb_pkg::RIDX_W-1:0] receptor_index;
	logic last_pair;

	// Transactions waiting for the driver and pairs waiting for the monitor.
	atom_item_t atom_items[$];
	pair_t awaited_pairs[$];
	atom_item_t on_wire;
	pair_t seen_pair;

	// Local copy of the receptor store and the registers.
	logic signed [cplb_pkg::FIELD_W-1:0] recep_x[STORE_DEPTH];
	logic signed [cplb_pkg::FIELD_W-1:0] recep_y[STORE_DEPTH];
	logic signed [cplb_pkg::FIELD_W-1:0] recep_z[STORE_DEPTH];
	logic recep_act[STORE_DEPTH];
	int recep_count = 0;
	logic [cplb_pkg::CUTOFF_W-1:0] cut_sq = '0;
	logic every_pair = 1'b0;

	int items_sent = 0;
	int items_taken = 0;
	int gap_left = 0;
	int stall_left = 0;
	int errors = 0;
	bit quiet = 1'b0;

	cutoff_pair_list_builder DUT (
		.clk(clk),
		.arst_n(arst_n),
		.cfg_write_en(cfg_write_en),
		.cfg_index(cfg_index),
		.cfg_data(cfg_data),
		.in_valid(in_valid),
		.in_stall(in_stall),
		.kind(kind),
		.atom_x(atom_x),
		.atom_y(atom_y),
		.atom_z(atom_z),
		.atom_active(atom_active),
		.ligand_number(ligand_number),
		.out_valid(out_valid),
		.out_stall(out_stall),
		.ligand_index(ligand_index),
		.receptor_index(receptor_index),
		.last_pair(last_pair)
	);

	always #4 clk = ~clk;

	task automatic report_mismatch(input string msg);
		$display("tb: mismatch: %s", msg);
		errors++;
	endtask

	// Mostly short idle stretches, now and then a long one.
	function automatic int idle_len();
		if ($urandom_range(0, 99) < 85)
			return $urandom_range(1, 3);
		return $urandom_range(8, 24);
	endfunction

	// A random value of one coordinate or ligand field.
	function automatic logic [cplb_pkg::FIELD_W-1:0] rand_field();
		logic [31:0] v;
		v = $urandom;
		return v[cplb_pkg::FIELD_W-1:0];
	endfunction

	// A coordinate within spread of center, wrapped to the field width.
	function automatic logic [cplb_pkg::FIELD_W-1:0] near(
			input logic [cplb_pkg::FIELD_W-1:0] center, input int spread);
		logic [31:0] v;
		v = center + $urandom_range(0, 2 * spread) - spread;
		return v[cplb_pkg::FIELD_W-1:0];
	endfunction

	// Updates the store copy for one transaction and lists the pairs it gives.
	task automatic find_pairs(input atom_item_t it);
		longint dx;
		longint dy;
		longint dz;
		longint d2;
		bit take;
		bit have_held;
		pair_t held;
		have_held = 1'b0;
		case (it.kind)
			cplb_pkg::KIND_CLEAR: recep_count = 0;
			cplb_pkg::KIND_APPEND: begin
				if (recep_count < STORE_DEPTH) begin
					recep_x[recep_count] = it.x;
					recep_y[recep_count] = it.y;
					recep_z[recep_count] = it.z;
					recep_act[recep_count] = it.active;
					recep_count++;
				end
			end
			cplb_pkg::KIND_QUERY: begin
				for (int j = 0; j < recep_count; j++) begin
					if (every_pair) begin
						take = 1'b1;
					end else if (!it.active || !recep_act[j]) begin
						take = 1'b0;
					end else begin
						dx = longint'(it.x) - longint'(recep_x[j]);
						dy = longint'(it.y) - longint'(recep_y[j]);
						dz = longint'(it.z) - longint'(recep_z[j]);
						d2 = dx * dx + dy * dy + dz * dz;
						take = (d2 <= longint'(cut_sq));
					end
					if (take) begin
						if (have_held)
							awaited_pairs.insert(awaited_pairs.size(), held);
						held.lig = it.lig;
						held.ridx = cplb_pkg::RIDX_W'(j);
						held.last = 1'b0;
						have_held = 1'b1;
					end
				end
				// The final pair of the query carries the last mark.
				if (have_held) begin
					held.last = 1'b1;
					awaited_pairs.insert(awaited_pairs.size(), held);
				end
			end
			default: ;
		endcase
	endtask

	// Input driver: takes transactions from the queue, with random gaps.
	always @(posedge clk) begin
		if (arst_n) begin
			if (in_valid && !in_stall) begin
				find_pairs(on_wire);
				items_taken++;
			end
			if (!in_valid || !in_stall) begin
				if (gap_left > 0) begin
					gap_left--;
					in_valid <= 1'b0;
				end else if (atom_items.size() > 0) begin
					on_wire = atom_items.pop_front();
					kind <= on_wire.kind;
					atom_x <= on_wire.x;
					atom_y <= on_wire.y;
					atom_z <= on_wire.z;
					atom_active <= on_wire.active;
					ligand_number <= on_wire.lig;
					in_valid <= 1'b1;
					gap_left = (quiet || $urandom_range(0, 1) == 0) ? 0 : idle_len();
				end else begin
					in_valid <= 1'b0;
				end
			end
		end
	end

	// Output stall generator.
	always @(posedge clk) begin
		if (stall_left > 0) begin
			stall_left--;
			out_stall <= 1'b1;
		end else if (!quiet && $urandom_range(0, 99) < 20) begin
			stall_left = idle_len() - 1;
			out_stall <= 1'b1;
		end else begin
			out_stall <= 1'b0;
		end
	end

	// Output monitor: each pair must match the oldest predicted pair.
	always @(posedge clk) begin
		if (arst_n && out_valid && !out_stall) begin
			if (awaited_pairs.size() == 0) begin
				report_mismatch($sformatf("unexpected pair ligand %0d receptor %0d",
					ligand_index, receptor_index));
			end else begin
				seen_pair = awaited_pairs.pop_front();
				if (ligand_index !== seen_pair.lig)
					report_mismatch($sformatf("ligand_index %0d, predicted %0d",
						ligand_index, seen_pair.lig));
				if (receptor_index !== seen_pair.ridx)
					report_mismatch($sformatf("receptor_index %0d, predicted %0d",
						receptor_index, seen_pair.ridx));
				if (last_pair !== seen_pair.last)
					report_mismatch($sformatf("last_pair %0d, predicted %0d (ligand %0d)",
						last_pair, seen_pair.last, seen_pair.lig));
			end
		end
	end

	// Queues one transaction for the driver.
	task automatic add_atom(input logic [cplb_pkg::KIND_W-1:0] k,
			input logic [cplb_pkg::FIELD_W-1:0] x,
			input logic [cplb_pkg::FIELD_W-1:0] y, input logic [cplb_pkg::FIELD_W-1:0] z,
			input logic act, input logic [cplb_pkg::LIG_W-1:0] lig);
		atom_item_t it;
		it.kind = k;
		it.x = x;
		it.y = y;
		it.z = z;
		it.active = act;
		it.lig = lig;
		atom_items.insert(atom_items.size(), it);
		items_sent++;
	endtask

	// Holds off until every transaction is taken and every pair has come out,
	// then lets a silent query run out.
	task automatic settle();
		while (items_taken != items_sent || awaited_pairs.size() != 0)
			@(posedge clk);
		repeat (DRAIN_CYCLES) @(posedge clk);
	endtask

	task automatic write_reg(input logic [cplb_pkg::CFG_INDEX_W-1:0] idx,
			input logic [cplb_pkg::CFG_DATA_W-1:0] data);
		@(posedge clk);
		cfg_write_en <= 1'b1;
		cfg_index <= idx;
		cfg_data <= data;
		if (idx == cplb_pkg::REG_SQUARED_CUTOFF)
			cut_sq = data[cplb_pkg::CUTOFF_W-1:0];
		else
			every_pair = data[0];
		@(posedge clk);
		cfg_write_en <= 1'b0;
	endtask

	// Timeout guard.
	initial begin
		repeat (CYCLE_LIMIT) @(posedge clk);
		$display("tb: done, errors");
		$finish;
	end

	// Stimulus sequencer.
	initial begin
		int spread;
		int style;
		int n_app;
		int n_q;
		int start_sent;
		bit first;
		logic [cplb_pkg::FIELD_W-1:0] cx;
		logic [cplb_pkg::FIELD_W-1:0] cy;
		logic [cplb_pkg::FIELD_W-1:0] cz;
		logic [63:0] wide;
		logic [cplb_pkg::CFG_DATA_W-1:0] cut_val;
		logic mode_val;

		repeat (10) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// Reset settings: zero cutoff, filtering on. An empty store gives nothing.
		add_atom(cplb_pkg::KIND_QUERY, 16'h0000, 16'h0000, 16'h0000, 1'b1, 16'h0000);
		add_atom(KIND_UNUSED, 16'hFFFF, 16'hFFFF, 16'hFFFF, 1'b1, 16'hFFFF);
		add_atom(cplb_pkg::KIND_APPEND, 16'h8000, 16'h8000, 16'h8000, 1'b1, 16'h0000);
		add_atom(cplb_pkg::KIND_APPEND, 16'h7FFF, 16'h7FFF, 16'h7FFF, 1'b1, 16'h0000);
		add_atom(cplb_pkg::KIND_APPEND, 16'h0000, 16'h0000, 16'h0000, 1'b1, 16'h0000);
		add_atom(cplb_pkg::KIND_APPEND, 16'h0000, 16'h0000, 16'h0000, 1'b0, 16'h0000);
		add_atom(cplb_pkg::KIND_APPEND, 16'h0001, 16'h0000, 16'h0000, 1'b1, 16'h0000);
		add_atom(cplb_pkg::KIND_QUERY, 16'h0000, 16'h0000, 16'h0000, 1'b1, 16'hFFFF);
		add_atom(cplb_pkg::KIND_QUERY, 16'h0000, 16'h0000, 16'h0000, 1'b0, 16'h1234);
		add_atom(cplb_pkg::KIND_QUERY, 16'h8000, 16'h8000, 16'h8000, 1'b1, 16'h5555);
		settle();

		// Largest cutoff: opposite corners of the coordinate cube still pair.
		write_reg(cplb_pkg::REG_SQUARED_CUTOFF, CUTOFF_MAX);
		add_atom(cplb_pkg::KIND_QUERY, 16'h8000, 16'h8000, 16'h8000, 1'b1, 16'hAAAA);
		add_atom(cplb_pkg::KIND_QUERY, 16'h7FFF, 16'h7FFF, 16'h7FFF, 1'b0, 16'h0001);
		settle();

		// A cutoff of one sits exactly on the unit distance.
		write_reg(cplb_pkg::REG_SQUARED_CUTOFF, 36'd1);
		add_atom(cplb_pkg::KIND_QUERY, 16'h0000, 16'h0000, 16'h0000, 1'b1, 16'h0002);
		add_atom(cplb_pkg::KIND_QUERY, 16'h0000, 16'h0000, 16'h0001, 1'b1, 16'h0003);
		settle();

		// All-pairs mode ignores distance and the active flags.
		write_reg(cplb_pkg::REG_ALL_PAIRS_MODE, 36'd1);
		add_atom(cplb_pkg::KIND_QUERY, 16'h0000, 16'h0000, 16'h0000, 1'b0, 16'h0004);
		add_atom(cplb_pkg::KIND_CLEAR, 16'h0000, 16'h0000, 16'h0000, 1'b0, 16'h0000);
		add_atom(cplb_pkg::KIND_QUERY, 16'h0000, 16'h0000, 16'h0000, 1'b1, 16'h0005);
		add_atom(cplb_pkg::KIND_APPEND, 16'h000C, 16'hFFF9, 16'h0003, 1'b0, 16'h0000);
		add_atom(cplb_pkg::KIND_QUERY, 16'h0100, 16'h0200, 16'h0300, 1'b0, 16'h0006);
		settle();

		// Random phases: a fresh register setting, then a cluster of receptor
		// atoms and queries around it. The first phase overfills the store.
		start_sent = items_sent;
		first = 1'b1;
		while (items_sent - start_sent < RANDOM_ITEMS) begin
			style = first ? 0 : $urandom_range(0, 9);
			mode_val = (style == 2) || ($urandom_range(0, 9) == 0);
			if (style <= 2)
				spread = 32768;
			else
				spread = 1 << $urandom_range(2, 12);
			wide = {$urandom, $urandom};
			if (style == 0)
				cut_val = CUTOFF_MAX;
			else if (style == 1)
				cut_val = wide[cplb_pkg::CFG_DATA_W-1:0];
			else if (style == 3)
				cut_val = '0;
			else
				cut_val = cplb_pkg::CFG_DATA_W'($urandom_range(0, 3 * spread * spread));
			write_reg(cplb_pkg::REG_SQUARED_CUTOFF, cut_val);
			// Only bit zero of the mode write carries meaning.
			wide = {$urandom, $urandom};
			write_reg(cplb_pkg::REG_ALL_PAIRS_MODE, {wide[cplb_pkg::CFG_DATA_W-1:1], mode_val});
			quiet = ($urandom_range(0, 3) == 0);

			cx = rand_field();
			cy = rand_field();
			cz = rand_field();
			if (first || $urandom_range(0, 4) != 0)
				add_atom(cplb_pkg::KIND_CLEAR, rand_field(), rand_field(), rand_field(),
					$urandom_range(0, 1) == 1, rand_field());
			if (first)
				n_app = STORE_DEPTH + 6;
			else if ($urandom_range(0, 7) == 0)
				n_app = $urandom_range(30, STORE_DEPTH + 4);
			else
				n_app = $urandom_range(1, 16);
			n_q = $urandom_range(2, 8);
			// Occasionally query before the store is refilled.
			if ($urandom_range(0, 5) == 0)
				add_atom(cplb_pkg::KIND_QUERY, near(cx, spread), near(cy, spread),
					near(cz, spread), 1'b1, rand_field());
			while (n_app > 0 || n_q > 0) begin
				if ($urandom_range(0, 19) == 0)
					add_atom(KIND_UNUSED, rand_field(), rand_field(), rand_field(),
						$urandom_range(0, 1) == 1, rand_field());
				if (n_app > 0 && (n_q == 0 || $urandom_range(0, 3) != 0)) begin
					add_atom(cplb_pkg::KIND_APPEND, near(cx, spread), near(cy, spread),
						near(cz, spread), $urandom_range(0, 99) < 85, rand_field());
					n_app--;
				end else begin
					add_atom(cplb_pkg::KIND_QUERY, near(cx, spread), near(cy, spread),
						near(cz, spread), $urandom_range(0, 99) < 85, rand_field());
					n_q--;
				end
			end
			first = 1'b0;
			settle();
		end

		if (awaited_pairs.size() != 0)
			report_mismatch($sformatf("%0d predicted pairs never came out",
				awaited_pairs.size()));
		if (errors == 0)
			$display("tb: done, clean");
		else
			$display("tb: done, errors");
		$finish;
	end

endmodule

@@ sim.f @@
sv/cplb_pkg.sv
sv/cplb_ram.sv
sv/cplb_ctrl.sv
sv/cplb_datapath.sv
sv/cutoff_pair_list_builder.sv
verif/tb.sv
